// ===== rtl/jpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// jpdt_pkg
// Shared widths, register map and reset values of the joint PD torque unit.
// ----------------------------------------------------------------------------
package jpdt_pkg;

  localparam int unsigned JointsDefault = 7;
  localparam int unsigned JointW        = 3;
  localparam int unsigned DataW         = 32;
  localparam int unsigned GainW         = 31;
  localparam int unsigned AlphaW        = 17;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned PaddrW        = 5;

  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);
  localparam logic [GainW-1:0]  GainMax  = '1;

  localparam logic [AlphaW-1:0] AlphaRst     = AlphaW'(64880);
  localparam logic [GainW-1:0]  RateLimRst   = GainW'(65536);
  localparam logic [GainW-1:0]  TorqueLimRst = GainW'(5701632);
  localparam logic [GainW-1:0]  StiffRst     = GainW'(41343795);
  localparam logic [GainW-1:0]  DampRst      = GainW'(2302566);
  localparam logic [GainW-1:0]  FixedKpRst   = GainW'(2621440);
  localparam logic [GainW-1:0]  FixedKdRst   = GainW'(2621440);

  typedef enum logic [2:0] {
    RegFilterAlpha  = 3'd0,
    RegRateLimit    = 3'd1,
    RegTorqueLimit  = 3'd2,
    RegUseVarying   = 3'd3,
    RegStiffScale   = 3'd4,
    RegDampScale    = 3'd5,
    RegFixedKp      = 3'd6,
    RegFixedKd      = 3'd7
  } cfg_reg_e;

endpackage

// ===== rtl/jpdt_if.sv =====
// ----------------------------------------------------------------------------
// jpdt_in_if / jpdt_out_if
// Valid/ready channels carrying one joint sample and one torque command.
// ----------------------------------------------------------------------------
interface jpdt_in_if;
  import jpdt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [JointW-1:0]        joint_index;
  logic signed [DataW-1:0]  q_target;
  logic signed [DataW-1:0]  v_target;
  logic signed [DataW-1:0]  tau_feedforward;
  logic signed [DataW-1:0]  q_measured;
  logic signed [DataW-1:0]  dq_measured;
  logic signed [DataW-1:0]  tau_last_commanded;
  logic [GainW-1:0]         mass_diagonal;

  modport source (
    output valid, joint_index, q_target, v_target, tau_feedforward,
           q_measured, dq_measured, tau_last_commanded, mass_diagonal,
    input  ready
  );
  modport sink (
    input  valid, joint_index, q_target, v_target, tau_feedforward,
           q_measured, dq_measured, tau_last_commanded, mass_diagonal,
    output ready
  );
endinterface

interface jpdt_out_if;
  import jpdt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [JointW-1:0]        joint_out;
  logic signed [DataW-1:0]  torque_command;

  modport source (output valid, joint_out, torque_command, input ready);
  modport sink   (input valid, joint_out, torque_command, output ready);
endinterface

// ===== rtl/joint_pd_torque_with_rate_limit_unit.sv =====
// ----------------------------------------------------------------------------
// joint_pd_torque_with_rate_limit_unit
// PD joint torque with filtered velocity, torque clamp and rate limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one joint sample per item, out_o one torque command per
//   item, valid/ready on both. Gains, limits and the filter weight sit in
//   APB registers at byte address 4*index; write them only while idle.
//   The result register loads at the end of ten sequencer steps, six of
//   them on the single shared 33x32 multiplier (two filter products, two
//   derived gains, two PD terms), then clamp, difference and rate limit.
//   One item is in flight at a time and the sequencer passes back through
//   its idle state before it accepts again, so the next sample is taken
//   only once the last one has reached the output register.
//   The per-joint filtered velocity lives in a small synchronous RAM, read at
//   acceptance and written back after the filter step.
//   Reset clears the registers to their defaults and the per-joint valid
//   bits, so every joint starts from zero velocity; no clearing pass runs.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and waits at its last step until that register
//   frees.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_rate_limit_unit #(
  parameter int unsigned Joints = jpdt_pkg::JointsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jpdt_in_if.sink                        in_i,
  jpdt_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jpdt_pkg::PaddrW-1:0]    paddr,
  input  logic [jpdt_pkg::ApbDataW-1:0]  pwdata,
  output logic [jpdt_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import jpdt_pkg::*;

  localparam int unsigned IdxW = (Joints > 1) ? $clog2(Joints) : 1;
  localparam int unsigned CntW = 5;

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StFilt0 = 11'b000_0000_0010,
    StFilt1 = 11'b000_0000_0100,
    StFilt2 = 11'b000_0000_1000,
    StGain0 = 11'b000_0001_0000,
    StGain1 = 11'b000_0010_0000,
    StTerm0 = 11'b000_0100_0000,
    StTerm1 = 11'b000_1000_0000,
    StClamp = 11'b001_0000_0000,
    StDiff  = 11'b010_0000_0000,
    StOut   = 11'b100_0000_0000
  } state_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [48:0] rnd16(input logic signed [64:0] p);
    logic signed [64:0] t;
    t = p + 65'sd32768;
    return t[64:16];
  endfunction

  function automatic logic [GainW-1:0] sat_gain(input logic signed [64:0] p);
    logic [62:0] t;
    t = p[62:0] + 63'd32768;
    if (|t[62:47]) return GainMax;
    return t[46:16];
  endfunction

  function automatic logic signed [50:0] clamp_lim(input logic signed [50:0] x,
                                                   input logic [GainW-1:0] lim);
    logic signed [50:0] l;
    l = signed'({20'b0, lim});
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  // -------------------------------------------------------------- registers
  logic [AlphaW-1:0] filter_alpha_q;
  logic [GainW-1:0]  rate_limit_q, torque_limit_q, stiff_q, damp_q;
  logic [GainW-1:0]  fixed_kp_q, fixed_kd_q;
  logic              use_varying_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[PaddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_alpha_q <= AlphaRst;
      rate_limit_q   <= RateLimRst;
      torque_limit_q <= TorqueLimRst;
      use_varying_q  <= 1'b0;
      stiff_q        <= StiffRst;
      damp_q         <= DampRst;
      fixed_kp_q     <= FixedKpRst;
      fixed_kd_q     <= FixedKdRst;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegFilterAlpha: filter_alpha_q <= pwdata[AlphaW-1:0];
        RegRateLimit:   rate_limit_q   <= pwdata[GainW-1:0];
        RegTorqueLimit: torque_limit_q <= pwdata[GainW-1:0];
        RegUseVarying:  use_varying_q  <= pwdata[0];
        RegStiffScale:  stiff_q        <= pwdata[GainW-1:0];
        RegDampScale:   damp_q         <= pwdata[GainW-1:0];
        RegFixedKp:     fixed_kp_q     <= pwdata[GainW-1:0];
        RegFixedKd:     fixed_kd_q     <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegFilterAlpha: prdata = ApbDataW'(filter_alpha_q);
      RegRateLimit:   prdata = ApbDataW'(rate_limit_q);
      RegTorqueLimit: prdata = ApbDataW'(torque_limit_q);
      RegUseVarying:  prdata = ApbDataW'(use_varying_q);
      RegStiffScale:  prdata = ApbDataW'(stiff_q);
      RegDampScale:   prdata = ApbDataW'(damp_q);
      RegFixedKp:     prdata = ApbDataW'(fixed_kp_q);
      RegFixedKd:     prdata = ApbDataW'(fixed_kd_q);
      default:        prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- sequencer
  state_e state_q, state_d;
  logic   accept, out_load, out_vld_q;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid & in_i.ready;
  assign out_load   = (state_q == StOut) & (~out_vld_q | out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StFilt0;
      StFilt0: state_d = StFilt1;
      StFilt1: state_d = StFilt2;
      StFilt2: state_d = StGain0;
      StGain0: state_d = StGain1;
      StGain1: state_d = StTerm0;
      StTerm0: state_d = StTerm1;
      StTerm1: state_d = StClamp;
      StClamp: state_d = StDiff;
      StDiff:  state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------- item capture
  logic [JointW-1:0]       joint_q;
  logic signed [DataW-1:0] qt_q, vt_q, ff_q, qm_q, dq_q, last_q;
  logic [GainW-1:0]        mass_q;
  logic [IdxW-1:0]         idx, idx_q;
  logic                    jvalid, jvalid_q, fvld_q;

  assign idx    = IdxW'(in_i.joint_index);
  assign jvalid = ({2'b0, in_i.joint_index} < CntW'(Joints));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q <= in_i.joint_index;
      qt_q    <= in_i.q_target;
      vt_q    <= in_i.v_target;
      ff_q    <= in_i.tau_feedforward;
      qm_q    <= in_i.q_measured;
      dq_q    <= in_i.dq_measured;
      last_q  <= in_i.tau_last_commanded;
      mass_q  <= in_i.mass_diagonal;
      idx_q   <= idx;
    end
  end

  // ------------------------------------------------- filtered velocity RAM
  // One item at a time: the write-back always lands before the next read.
  logic [DataW-1:0]        fv_mem [Joints];
  logic [DataW-1:0]        rdata_q;
  logic [Joints-1:0]       vld_q;
  logic signed [DataW-1:0] f_d, f_q;
  logic                    fv_wr;

  assign fv_wr = (state_q == StFilt2) & jvalid_q;

  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= fv_mem[idx];
    if (fv_wr)  fv_mem[idx_q] <= f_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      jvalid_q <= 1'b0;
      fvld_q   <= 1'b0;
    end else begin
      if (accept) begin
        jvalid_q <= jvalid;
        fvld_q   <= jvalid & vld_q[idx];
      end
      if (fv_wr) vld_q[idx_q] <= 1'b1;
    end
  end

  // ------------------------------------------------------ shared multiplier
  logic [AlphaW-1:0]       a_eff, one_minus_a;
  logic signed [DataW-1:0] f_prev;
  logic signed [32:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [64:0]      prod_q;

  assign a_eff       = (filter_alpha_q > AlphaOne) ? AlphaOne : filter_alpha_q;
  assign one_minus_a = AlphaOne - a_eff;
  assign f_prev      = fvld_q ? signed'(rdata_q) : '0;

  logic [GainW-1:0] kp_q, kd_q;

  always_comb begin
    case (state_q)
      StFilt0: begin
        mul_a = 33'(f_prev);
        mul_b = signed'({15'b0, one_minus_a});
      end
      StFilt1: begin
        mul_a = 33'(dq_q);
        mul_b = signed'({15'b0, a_eff});
      end
      StFilt2: begin
        mul_a = signed'({2'b0, mass_q});
        mul_b = signed'({1'b0, stiff_q});
      end
      StGain0: begin
        mul_a = signed'({2'b0, mass_q});
        mul_b = signed'({1'b0, damp_q});
      end
      StGain1: begin
        mul_a = 33'(qt_q) - 33'(qm_q);
        mul_b = signed'({1'b0, kp_q});
      end
      StTerm0: begin
        mul_a = 33'(vt_q) - 33'(f_q);
        mul_b = signed'({1'b0, kd_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 65'(mul_a) * 65'(mul_b);
  end

  // ---------------------------------------------------------- accumulation
  logic signed [49:0] acc_q, filt_sum;
  logic signed [50:0] tau_q, lim_tau;
  logic [JointW-1:0]  joint_out_q;
  logic [DataW-1:0]   torque_q;

  assign filt_sum = acc_q + prod_q[49:0];
  assign f_d      = filt_sum[47:16];
  assign lim_tau  = 51'(last_q) + clamp_lim(tau_q, rate_limit_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      StFilt1: acc_q <= prod_q[49:0] + 50'sd32768;
      StFilt2: f_q   <= f_d;
      StGain0: kp_q  <= use_varying_q ? sat_gain(prod_q) : fixed_kp_q;
      StGain1: kd_q  <= use_varying_q ? sat_gain(prod_q) : fixed_kd_q;
      StTerm0: tau_q <= 51'(ff_q) + 51'(rnd16(prod_q));
      StTerm1: tau_q <= tau_q + 51'(rnd16(prod_q));
      StClamp: tau_q <= clamp_lim(tau_q, torque_limit_q);
      StDiff:  tau_q <= tau_q - 51'(last_q);
      default: ;
    endcase
    if (out_load) begin
      joint_out_q <= joint_q;
      torque_q    <= lim_tau[DataW-1:0];
    end
  end

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_vld_q <= 1'b0;
    else if (out_load)       out_vld_q <= 1'b1;
    else if (out_o.ready)    out_vld_q <= 1'b0;
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.joint_out      = joint_out_q;
  assign out_o.torque_command = signed'(torque_q);

endmodule

// ===== rtl/jpdt_checker.sv =====
// ----------------------------------------------------------------------------
// jpdt_checker
// Port-level assertions for the joint PD torque unit, bound to the top level.
// ----------------------------------------------------------------------------
module jpdt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [jpdt_pkg::JointW-1:0]    joint_out_i,
  input logic [jpdt_pkg::DataW-1:0]     torque_command_i,
  input logic                           psel_i,
  input logic                           penable_i,
  input logic                           pwrite_i,
  input logic [jpdt_pkg::PaddrW-1:0]    paddr_i,
  input logic [jpdt_pkg::ApbDataW-1:0]  pwdata_i,
  input logic [jpdt_pkg::ApbDataW-1:0]  prdata_i
);
  import jpdt_pkg::*;

  // one item in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  // a fresh result only comes out of the busy sequencer
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without an item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(joint_out_i) && $stable(torque_command_i))
    else $error("stalled result changed");

  // fixed_kp reads back what was written, masked to its width
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i && paddr_i[PaddrW-1:2] == RegFixedKp)
      ##1 (psel_i && !pwrite_i && paddr_i[PaddrW-1:2] == RegFixedKp)
      |-> prdata_i == {1'b0, $past(pwdata_i[GainW-1:0])})
    else $error("register readback mismatch");

endmodule

bind joint_pd_torque_with_rate_limit_unit jpdt_checker u_jpdt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .joint_out_i      (out_o.joint_out),
  .torque_command_i (out_o.torque_command),
  .psel_i           (psel),
  .penable_i        (penable),
  .pwrite_i         (pwrite),
  .paddr_i          (paddr),
  .pwdata_i         (pwdata),
  .prdata_i         (prdata)
);

// ===== dv/jpdt_torque_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpdt_torque_check
// Watches the register port and both item channels of the joint PD torque
// unit, predicts every torque command from its own copy of the registers
// and the per-joint filtered velocity, and compares each command in order.
// ----------------------------------------------------------------------------
module jpdt_torque_check #(
  parameter int unsigned Joints = jpdt_pkg::JointsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jpdt_in_if                             in_mon_i,
  jpdt_out_if                            out_mon_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [jpdt_pkg::PaddrW-1:0]    paddr_i,
  input  logic [jpdt_pkg::ApbDataW-1:0]  pwdata_i,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    open_cmds_o
);
  import jpdt_pkg::*;

  typedef struct packed {
    logic [JointW-1:0]       joint;
    logic signed [DataW-1:0] torque;
  } torque_cmd_t;

  logic signed [DataW-1:0] vel_filt [Joints];
  logic [AlphaW-1:0]       alpha_r;
  logic [GainW-1:0]        rate_lim_r;
  logic [GainW-1:0]        torque_lim_r;
  logic                    varying_r;
  logic [GainW-1:0]        stiff_r;
  logic [GainW-1:0]        damp_r;
  logic [GainW-1:0]        kp_r;
  logic [GainW-1:0]        kd_r;

  torque_cmd_t             expected_cmds [$];
  int unsigned             fails;

  // add half an LSB, then floor
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint derived_gain(input logic [GainW-1:0] scale,
                                          input logic [GainW-1:0] mass);
    longint p;
    p = (longint'(scale) * longint'(mass) + 64'sd32768) >>> 16;
    return (p > longint'(GainMax)) ? longint'(GainMax) : p;
  endfunction

  // Update the joint's filtered velocity and return the torque command.
  function automatic logic signed [DataW-1:0] predict_torque(
    input logic [JointW-1:0]       joint,
    input logic signed [DataW-1:0] q_tgt,
    input logic signed [DataW-1:0] v_tgt,
    input logic signed [DataW-1:0] tau_ff,
    input logic signed [DataW-1:0] q_meas,
    input logic signed [DataW-1:0] dq_meas,
    input logic signed [DataW-1:0] tau_last,
    input logic [GainW-1:0]        mass
  );
    longint a;
    longint f_prev;
    longint f;
    longint kp;
    longint kd;
    longint tau;
    a = (alpha_r > AlphaOne) ? longint'(AlphaOne) : longint'(alpha_r);
    f_prev = 0;
    if (joint < Joints) f_prev = longint'(vel_filt[joint]);
    f = round_q16((longint'(AlphaOne) - a) * f_prev + a * longint'(dq_meas));
    if (joint < Joints) vel_filt[joint] = f[DataW-1:0];
    if (varying_r) begin
      kp = derived_gain(stiff_r, mass);
      kd = derived_gain(damp_r, mass);
    end else begin
      kp = longint'(kp_r);
      kd = longint'(kd_r);
    end
    tau = longint'(tau_ff)
        + round_q16(kp * (longint'(q_tgt) - longint'(q_meas)))
        + round_q16(kd * (longint'(v_tgt) - f));
    tau = clamp_mag(tau, longint'(torque_lim_r));
    tau = longint'(tau_last)
        + clamp_mag(tau - longint'(tau_last), longint'(rate_lim_r));
    return tau[DataW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    torque_cmd_t cmd;
    if (!rst_ni) begin
      for (int j = 0; j < Joints; j++) vel_filt[j] = '0;
      alpha_r      = AlphaRst;
      rate_lim_r   = RateLimRst;
      torque_lim_r = TorqueLimRst;
      varying_r    = 1'b0;
      stiff_r      = StiffRst;
      damp_r       = DampRst;
      kp_r         = FixedKpRst;
      kd_r         = FixedKdRst;
      expected_cmds.delete();
      fails = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[PaddrW-1:2]))
          RegFilterAlpha: alpha_r      = pwdata_i[AlphaW-1:0];
          RegRateLimit:   rate_lim_r   = pwdata_i[GainW-1:0];
          RegTorqueLimit: torque_lim_r = pwdata_i[GainW-1:0];
          RegUseVarying:  varying_r    = pwdata_i[0];
          RegStiffScale:  stiff_r      = pwdata_i[GainW-1:0];
          RegDampScale:   damp_r       = pwdata_i[GainW-1:0];
          RegFixedKp:     kp_r         = pwdata_i[GainW-1:0];
          RegFixedKd:     kd_r         = pwdata_i[GainW-1:0];
          default: ;
        endcase
      end
      // retire before accepting: a new sample cannot produce this cycle's item
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected torque command, actual joint %0d torque %0d",
                   $time, out_mon_i.joint_out, out_mon_i.torque_command);
          fails++;
        end else begin
          cmd = expected_cmds.pop_front();
          if (out_mon_i.joint_out !== cmd.joint) begin
            $display("%0t: joint_out mismatch, expected %0d actual %0d",
                     $time, cmd.joint, out_mon_i.joint_out);
            fails++;
          end
          if (out_mon_i.torque_command !== cmd.torque) begin
            $display("%0t: torque_command mismatch (joint %0d), expected %0d actual %0d",
                     $time, cmd.joint, cmd.torque, out_mon_i.torque_command);
            fails++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        cmd.joint  = in_mon_i.joint_index;
        cmd.torque = predict_torque(in_mon_i.joint_index, in_mon_i.q_target,
                                    in_mon_i.v_target, in_mon_i.tau_feedforward,
                                    in_mon_i.q_measured, in_mon_i.dq_measured,
                                    in_mon_i.tau_last_commanded,
                                    in_mon_i.mass_diagonal);
        expected_cmds.insert(expected_cmds.size(), cmd);
      end
    end
    fail_cnt_o  <= fails;
    open_cmds_o <= expected_cmds.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives joint samples and register writes into the joint PD torque unit
// with random idle gaps on both channels, lets the checker predict and
// compare every torque command, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import jpdt_pkg::*;

  localparam int unsigned Phases        = 7;
  localparam int unsigned ItemsPerPhase = 230;
  localparam int unsigned LongHold      = 300;
  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;
  localparam logic [DataW-1:0] EdgeWords [4] =
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [JointW-1:0]       joint;
    logic signed [DataW-1:0] q_tgt;
    logic signed [DataW-1:0] v_tgt;
    logic signed [DataW-1:0] tau_ff;
    logic signed [DataW-1:0] q_meas;
    logic signed [DataW-1:0] dq_meas;
    logic signed [DataW-1:0] tau_last;
    logic [GainW-1:0]        mass;
  } joint_sample_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrW-1:0]    paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  int unsigned          fail_cnt;
  int unsigned          open_cmds;
  int unsigned          hold_ticket = 0;

  jpdt_in_if  in_if ();
  jpdt_out_if out_if ();

  always #1 clk_i = ~clk_i;

  joint_pd_torque_with_rate_limit_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jpdt_torque_check i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_if),
    .out_mon_i   (out_if),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_cnt_o  (fail_cnt),
    .open_cmds_o (open_cmds)
  );

  // mostly no gap, some short ones, a few long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return EdgeWords[$urandom_range(0, 3)];
      2, 3:    return DataW'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return DataW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [ApbDataW-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return $urandom_range(0, 1 << 23);
    endcase
  endfunction

  function automatic joint_sample_t mk_sample(
    input int j, input int qt, input int vt, input int ff,
    input int qm, input int dq, input int last, input int mass
  );
    joint_sample_t s;
    s = '{joint: JointW'(j), q_tgt: qt, v_tgt: vt, tau_ff: ff, q_meas: qm,
          dq_meas: dq, tau_last: last, mass: GainW'(mass)};
    return s;
  endfunction

  // hold valid until the item is taken, then idle for gap cycles
  task automatic offer_sample(input joint_sample_t s, input int unsigned gap);
    in_if.valid              <= 1'b1;
    in_if.joint_index        <= s.joint;
    in_if.q_target           <= s.q_tgt;
    in_if.v_target           <= s.v_tgt;
    in_if.tau_feedforward    <= s.tau_ff;
    in_if.q_measured         <= s.q_meas;
    in_if.dq_measured        <= s.dq_meas;
    in_if.tau_last_commanded <= s.tau_last;
    in_if.mass_diagonal      <= s.mass;
    do @(posedge clk_i); while (!in_if.ready);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every command has come back
  task automatic drain_cmds();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (open_cmds != 0);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [ApbDataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned served;
    int unsigned gap;
    served = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_ticket != served) begin
        served = hold_ticket;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = idle_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    joint_sample_t s;
    bit quiet;
    in_if.valid              <= 1'b0;
    in_if.joint_index        <= '0;
    in_if.q_target           <= '0;
    in_if.v_target           <= '0;
    in_if.tau_feedforward    <= '0;
    in_if.q_measured         <= '0;
    in_if.dq_measured        <= '0;
    in_if.tau_last_commanded <= '0;
    in_if.mass_diagonal      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every joint, an out-of-range joint, field extremes
    offer_sample(mk_sample(0, 0, 0, 0, 0, 0, 0, 0), idle_gap());
    for (int j = 1; j < 7; j++)
      offer_sample(mk_sample(j, j * 65536, 32768, -j * 4096, j * 60000,
                             -20000 * j, 1000 * j, 65536 * j), idle_gap());
    offer_sample(mk_sample(7, 65536, 0, 0, 0, 1 << 20, 0, 65536), idle_gap());
    offer_sample(mk_sample(0, QMax, 0, 0, QMin, 0, 0, 0), idle_gap());
    offer_sample(mk_sample(1, QMin, 0, 0, QMax, 0, 0, 0), idle_gap());
    offer_sample(mk_sample(2, 0, QMax, 0, 0, QMin, 0, 0), idle_gap());
    offer_sample(mk_sample(3, 0, QMin, 0, 0, QMax, 0, 0), idle_gap());
    offer_sample(mk_sample(4, 0, 0, QMax, 0, 0, QMax, 0), idle_gap());
    offer_sample(mk_sample(5, 0, 0, QMin, 0, 0, QMin, 0), idle_gap());

    // derived gains that saturate, alpha above one, widths masked on write
    drain_cmds();
    write_reg(RegUseVarying, 32'h0000_0001);
    write_reg(RegStiffScale, 32'hFFFF_FFFF);
    write_reg(RegDampScale, 32'hFFFF_FFFF);
    write_reg(RegFilterAlpha, 32'hFFFF_FFFF);
    write_reg(RegRateLimit, 32'hFFFF_FFFF);
    write_reg(RegTorqueLimit, 32'hFFFF_FFFF);
    offer_sample(mk_sample(2, 65536, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), idle_gap());
    offer_sample(mk_sample(2, 65536, 65536, 0, 0, 65536, 0, 0), idle_gap());
    offer_sample(mk_sample(6, QMax, QMin, 0, QMin, QMax, 0, 32'h7FFF_FFFF), idle_gap());
    offer_sample(mk_sample(7, QMin, QMax, 0, QMax, QMin, 0, 32'h7FFF_FFFF), idle_gap());
    offer_sample(mk_sample(3, 0, 0, 0, 0, -3 * 65536, 0, 65536), idle_gap());
    offer_sample(mk_sample(3, 0, 0, 0, 0, QMin, 0, 65536), idle_gap());

    for (int p = 0; p < Phases; p++) begin
      drain_cmds();
      case (p)
        0: begin
          write_reg(RegFilterAlpha, 32'(AlphaOne));
          write_reg(RegRateLimit, 32'hFFFF_FFFF);
          write_reg(RegTorqueLimit, 32'hFFFF_FFFF);
          write_reg(RegUseVarying, 32'h0);
          write_reg(RegFixedKp, rand_gain());
          write_reg(RegFixedKd, rand_gain());
        end
        1: begin
          write_reg(RegFilterAlpha, 32'h0);
          write_reg(RegRateLimit, 32'h0);
          write_reg(RegTorqueLimit, rand_gain());
          write_reg(RegUseVarying, 32'h1);
          write_reg(RegStiffScale, 32'h7FFF_FFFF);
          write_reg(RegDampScale, 32'h0);
        end
        2: begin
          write_reg(RegFilterAlpha, 32'(AlphaOne) + 32'd1);
          write_reg(RegRateLimit, rand_gain());
          write_reg(RegTorqueLimit, 32'h0);
          write_reg(RegStiffScale, rand_gain());
          write_reg(RegDampScale, rand_gain());
        end
        3: begin
          write_reg(RegFilterAlpha, $urandom_range(0, 131071));
          write_reg(RegRateLimit, rand_gain());
          write_reg(RegTorqueLimit, rand_gain());
          write_reg(RegUseVarying, 32'h0);
          write_reg(RegFixedKp, 32'h0);
          write_reg(RegFixedKd, 32'h7FFF_FFFF);
        end
        4: begin
          write_reg(RegFilterAlpha, $urandom_range(0, 65536));
          write_reg(RegRateLimit, rand_gain());
          write_reg(RegTorqueLimit, rand_gain());
          write_reg(RegUseVarying, 32'h1);
          write_reg(RegStiffScale, rand_gain());
          write_reg(RegDampScale, rand_gain());
        end
        5: begin
          write_reg(RegUseVarying, 32'h0);
          write_reg(RegFixedKp, 32'h7FFF_FFFF);
          write_reg(RegFixedKd, 32'h0);
          write_reg(RegTorqueLimit, 32'h7FFF_FFFF);
          write_reg(RegRateLimit, 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(RegFilterAlpha, 32'(AlphaRst));
          write_reg(RegRateLimit, 32'(RateLimRst));
          write_reg(RegTorqueLimit, 32'(TorqueLimRst));
          write_reg(RegUseVarying, 32'h0);
          write_reg(RegStiffScale, 32'(StiffRst));
          write_reg(RegDampScale, 32'(DampRst));
          write_reg(RegFixedKp, 32'(FixedKpRst));
          write_reg(RegFixedKd, 32'(FixedKdRst));
        end
      endcase

      // first phase: send back to back while the receiver holds off
      quiet = (p == 0);
      if (p == 0) hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p != 0 && n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (p == 3 && n == 100) drain_cmds();
        s.joint    = ($urandom_range(0, 9) == 0) ? JointW'(7) : JointW'($urandom_range(0, 6));
        s.q_tgt    = rand_q16();
        s.q_meas   = $urandom_range(0, 1)
                   ? s.q_tgt + DataW'(int'($urandom_range(0, 1 << 18)) - (1 << 17))
                   : rand_q16();
        s.v_tgt    = rand_q16();
        s.dq_meas  = $urandom_range(0, 1)
                   ? s.v_tgt + DataW'(int'($urandom_range(0, 1 << 18)) - (1 << 17))
                   : rand_q16();
        s.tau_ff   = rand_q16();
        s.tau_last = rand_q16();
        s.mass     = GainW'(rand_gain());
        offer_sample(s, quiet ? 0 : idle_gap());
      end
    end

    drain_cmds();
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== joint_pd_torque_with_rate_limit_unit.f =====
rtl/jpdt_pkg.sv
rtl/jpdt_if.sv
rtl/joint_pd_torque_with_rate_limit_unit.sv
rtl/jpdt_checker.sv
dv/jpdt_torque_check.sv
dv/tb_top.sv
